// ===== sv/csvtok_pkg.sv =====
// Shared types, constants and helper functions of the CSV record tokenizer.
`default_nettype none

package csvtok_pkg;

  // Fixed widths of the channel fields.
  localparam int unsigned LIMIT_W   = 13;
  localparam int unsigned POS_OUT_W = 12;
  localparam int unsigned LEN_OUT_W = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned REC_FIELDS = 3;

  // Reset values of the field limits.
  localparam logic [LIMIT_W-1:0] FIRST_LIMIT_RST = 13'd2048;
  localparam logic [LIMIT_W-1:0] OTHER_LIMIT_RST = 13'd256;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // UTF-8 byte order mark.
  localparam logic [1:0] BOM_LEN = 2'd3;
  localparam logic [7:0] BOM_B0  = 8'hEF;
  localparam logic [7:0] BOM_B1  = 8'hBB;
  localparam logic [7:0] BOM_B2  = 8'hBF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_LIMIT = 2'd0,
    CFG_OTHER_LIMIT = 2'd1
  } cfg_reg_e;

  // Kinds of result item.
  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_e;

  // One result item as it leaves the parser.
  typedef struct packed {
    kind_e                                 kind;
    logic [1:0]                            field_number;
    logic [POS_OUT_W-1:0]                  raw_position;
    logic [7:0]                            out_byte;
    logic [REC_FIELDS-1:0][POS_OUT_W-1:0]  start;
    logic [REC_FIELDS-1:0][LEN_OUT_W-1:0]  length;
    logic [REC_FIELDS-1:0]                 trunc_flags;
  } res_t;

  // Space, tab, newline, vertical tab, form feed and carriage return.
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Expected byte of the byte order mark at a given place.
  function automatic logic [7:0] bom_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = BOM_B0;
      2'd1:    b = BOM_B1;
      default: b = BOM_B2;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== sv/csvtok_in_if.sv =====
// Input channel: one data byte or an end-of-input mark per item.
`default_nettype none

interface csvtok_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/csvtok_out_if.sv =====
// Output channel: stored bytes and record bounds.
`default_nettype none

interface csvtok_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  field_number;
  logic [11:0] raw_position;
  logic [7:0]  out_byte;
  logic [11:0] first_start;
  logic [12:0] first_length;
  logic [11:0] second_start;
  logic [12:0] second_length;
  logic [11:0] third_start;
  logic [12:0] third_length;
  logic [2:0]  trunc_flags;

  modport source (output valid, output kind, output field_number, output raw_position,
                  output out_byte, output first_start, output first_length,
                  output second_start, output second_length, output third_start,
                  output third_length, output trunc_flags, input ready);
  modport sink   (input valid, input kind, input field_number, input raw_position,
                  input out_byte, input first_start, input first_length,
                  input second_start, input second_length, input third_start,
                  input third_length, input trunc_flags, output ready);
endinterface

`default_nettype wire

// ===== sv/csvtok_cfg_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none

interface csvtok_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/csvtok_cfg_regs.sv =====
// Configuration registers holding the two field limits.
`default_nettype none

module csvtok_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  csvtok_cfg_if.sink                       cfg_i,
  output logic [csvtok_pkg::LIMIT_W-1:0]   first_limit_o,
  output logic [csvtok_pkg::LIMIT_W-1:0]   other_limit_o
);

  logic [csvtok_pkg::LIMIT_W-1:0] first_limit_d, first_limit_q;
  logic [csvtok_pkg::LIMIT_W-1:0] other_limit_d, other_limit_q;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;

  // Register decode; unknown indexes leave both limits alone.
  always_comb begin
    first_limit_d = first_limit_q;
    other_limit_d = other_limit_q;
    if (cfg_i.valid) begin
      unique case (csvtok_pkg::cfg_reg_e'(cfg_i.index))
        csvtok_pkg::CFG_FIRST_LIMIT: first_limit_d = cfg_i.data;
        csvtok_pkg::CFG_OTHER_LIMIT: other_limit_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_limit_q <= csvtok_pkg::FIRST_LIMIT_RST;
      other_limit_q <= csvtok_pkg::OTHER_LIMIT_RST;
    end else begin
      first_limit_q <= first_limit_d;
      other_limit_q <= other_limit_d;
    end
  end

  assign first_limit_o = first_limit_q;
  assign other_limit_o = other_limit_q;

endmodule

`default_nettype wire

// ===== sv/csvtok_parser.sv =====
// Record parser: quote and field state, per-field counters and result forming.
`default_nettype none

module csvtok_parser #(
  parameter int unsigned POS_WIDTH   = 12,
  parameter int unsigned FIELD_COUNT = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic                            func_i,
  input  logic [7:0]                      byte_i,
  input  logic [csvtok_pkg::LIMIT_W-1:0]  first_limit_i,
  input  logic [csvtok_pkg::LIMIT_W-1:0]  other_limit_i,
  output logic                            res_valid_o,
  output csvtok_pkg::res_t                res_o
);

  localparam int unsigned CNT_W = POS_WIDTH + 1;
  localparam int unsigned FP_W  = $clog2(FIELD_COUNT + 1);
  localparam int unsigned LIM_W = (CNT_W > csvtok_pkg::LIMIT_W) ? CNT_W : csvtok_pkg::LIMIT_W;
  localparam logic [LIM_W-1:0] LIM_CAP = LIM_W'(1) << POS_WIDTH;

  // Record state.
  logic [FP_W-1:0]        field_pos_d, field_pos_q;
  logic                   in_quote_d, in_quote_q;
  logic                   quote_seen_d, quote_seen_q;
  logic                   started_d, started_q;
  logic                   has_data_d, has_data_q;
  logic [1:0]             bom_match_d, bom_match_q;
  logic [CNT_W-1:0]       raw_count_d [FIELD_COUNT];
  logic [CNT_W-1:0]       raw_count_q [FIELD_COUNT];
  logic [FIELD_COUNT-1:0] trunc_d, trunc_q;
  logic [CNT_W-1:0]       first_ns_d [FIELD_COUNT];
  logic [CNT_W-1:0]       first_ns_q [FIELD_COUNT];
  logic [FIELD_COUNT-1:0] first_valid_d, first_valid_q;
  logic [CNT_W-1:0]       last_end_d [FIELD_COUNT];
  logic [CNT_W-1:0]       last_end_q [FIELD_COUNT];
  logic [CNT_W-1:0]       ab_first_d, ab_first_q;
  logic                   ab_valid_d, ab_valid_q;

  // Limits capped at the position range.
  logic [LIM_W-1:0] first_ext, other_ext;
  logic [CNT_W-1:0] first_cap, other_cap;

  assign first_ext = LIM_W'(first_limit_i);
  assign other_ext = LIM_W'(other_limit_i);
  assign first_cap = (first_ext > LIM_CAP) ? CNT_W'(LIM_CAP) : CNT_W'(first_ext);
  assign other_cap = (other_ext > LIM_CAP) ? CNT_W'(LIM_CAP) : CNT_W'(other_ext);

  // Record bounds per reported field, formed from the current state.
  logic [csvtok_pkg::REC_FIELDS-1:0][csvtok_pkg::POS_OUT_W-1:0] rep_start;
  logic [csvtok_pkg::REC_FIELDS-1:0][csvtok_pkg::LEN_OUT_W-1:0] rep_len;
  logic [csvtok_pkg::REC_FIELDS-1:0]                             rep_trunc;

  for (genvar g = 0; g < csvtok_pkg::REC_FIELDS; g++) begin : gen_rep
    if (g < FIELD_COUNT) begin : gen_used
      logic             v;
      logic [CNT_W-1:0] s;

      // Field 0 starts after a complete byte order mark.
      always_comb begin
        v = first_valid_q[g];
        s = first_ns_q[g];
        if ((g == 0) && (bom_match_q == csvtok_pkg::BOM_LEN)) begin
          v = ab_valid_q;
          s = ab_first_q;
        end
        if (v && (last_end_q[g] > s)) begin
          rep_start[g] = csvtok_pkg::POS_OUT_W'(s);
          rep_len[g]   = csvtok_pkg::LEN_OUT_W'(last_end_q[g] - s);
        end else begin
          rep_start[g] = '0;
          rep_len[g]   = '0;
        end
        rep_trunc[g] = trunc_q[g];
      end
    end else begin : gen_unused
      assign rep_start[g] = '0;
      assign rep_len[g]   = '0;
      assign rep_trunc[g] = 1'b0;
    end
  end

  // Item decode and state update.
  logic                 keep, rec_end, empty_end, stored, handled;
  logic                 is_quote, is_comma, is_cr, is_lf, nonspace;
  logic [CNT_W-1:0]     pos;
  logic [CNT_W-1:0]     lim;

  always_comb begin
    field_pos_d   = field_pos_q;
    in_quote_d    = in_quote_q;
    quote_seen_d  = quote_seen_q;
    started_d     = started_q;
    has_data_d    = has_data_q;
    bom_match_d   = bom_match_q;
    raw_count_d   = raw_count_q;
    trunc_d       = trunc_q;
    first_ns_d    = first_ns_q;
    first_valid_d = first_valid_q;
    last_end_d    = last_end_q;
    ab_first_d    = ab_first_q;
    ab_valid_d    = ab_valid_q;
    keep          = 1'b0;
    rec_end       = 1'b0;
    empty_end     = 1'b0;
    stored        = 1'b0;
    handled       = 1'b0;
    pos           = '0;
    lim           = '0;
    is_quote      = (byte_i == csvtok_pkg::CH_QUOTE);
    is_comma      = (byte_i == csvtok_pkg::CH_COMMA);
    is_cr         = (byte_i == csvtok_pkg::CH_CR);
    is_lf         = (byte_i == csvtok_pkg::CH_LF);
    nonspace      = !csvtok_pkg::is_space(byte_i);

    if (func_i) begin
      if (!started_q) empty_end = 1'b1;
      else            rec_end   = 1'b1;
    end else begin
      // Quoted field: a doubled quote is data, a lone quote closes it.
      if (in_quote_q && quote_seen_q && is_quote) begin
        quote_seen_d = 1'b0;
        has_data_d   = 1'b1;
        started_d    = 1'b1;
        keep         = 1'b1;
        handled      = 1'b1;
      end else if (in_quote_q && quote_seen_q) begin
        in_quote_d   = 1'b0;
        quote_seen_d = 1'b0;
      end else if (in_quote_q) begin
        started_d = 1'b1;
        handled   = 1'b1;
        if (is_quote) begin
          quote_seen_d = 1'b1;
        end else begin
          has_data_d = 1'b1;
          keep       = 1'b1;
        end
      end

      // Outside quotes.
      if (!handled) begin
        if (is_quote) begin
          if (!has_data_q) in_quote_d = 1'b1;
          else             keep       = 1'b1;
          has_data_d = 1'b1;
          started_d  = 1'b1;
        end else if (is_comma) begin
          if (field_pos_q != FP_W'(FIELD_COUNT)) field_pos_d = field_pos_q + FP_W'(1);
          has_data_d = 1'b0;
          started_d  = 1'b1;
        end else if (is_cr) begin
          // Carriage return outside quotes is dropped.
        end else if (is_lf) begin
          if (started_q || has_data_q || (field_pos_q != '0)) rec_end = 1'b1;
        end else begin
          has_data_d = 1'b1;
          started_d  = 1'b1;
          keep       = 1'b1;
        end
      end
    end

    // Store the byte in the current field, or flag truncation.
    for (int i = 0; i < FIELD_COUNT; i++) begin
      if (keep && (field_pos_q == FP_W'(i))) begin
        lim = (i == 0) ? first_cap : other_cap;
        if (raw_count_q[i] >= lim) begin
          trunc_d[i] = 1'b1;
        end else begin
          stored = 1'b1;
          pos    = raw_count_q[i];
          if (nonspace) begin
            if (!first_valid_q[i]) begin
              first_valid_d[i] = 1'b1;
              first_ns_d[i]    = raw_count_q[i];
            end
            last_end_d[i] = raw_count_q[i] + CNT_W'(1);
            if ((i == 0) && (raw_count_q[i] >= CNT_W'(csvtok_pkg::BOM_LEN)) && !ab_valid_q) begin
              ab_valid_d = 1'b1;
              ab_first_d = raw_count_q[i];
            end
          end
          if ((i == 0) && (raw_count_q[i] < CNT_W'(csvtok_pkg::BOM_LEN)) &&
              (CNT_W'(bom_match_q) == raw_count_q[i]) &&
              (byte_i == csvtok_pkg::bom_byte(bom_match_q))) begin
            bom_match_d = bom_match_q + 2'd1;
          end
          raw_count_d[i] = raw_count_q[i] + CNT_W'(1);
        end
      end
    end

    // A record end or end of input clears the whole record.
    if (rec_end || empty_end) begin
      field_pos_d   = '0;
      in_quote_d    = 1'b0;
      quote_seen_d  = 1'b0;
      started_d     = 1'b0;
      has_data_d    = 1'b0;
      bom_match_d   = '0;
      trunc_d       = '0;
      first_valid_d = '0;
      ab_first_d    = '0;
      ab_valid_d    = 1'b0;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        raw_count_d[i] = '0;
        first_ns_d[i]  = '0;
        last_end_d[i]  = '0;
      end
    end
  end

  // Result forming; fields that do not belong to the kind stay zero.
  always_comb begin
    res_o       = '0;
    res_valid_o = stored || rec_end || empty_end;
    if (stored) begin
      res_o.kind         = csvtok_pkg::KIND_BYTE;
      res_o.field_number = 2'(field_pos_q);
      res_o.raw_position = csvtok_pkg::POS_OUT_W'(pos);
      res_o.out_byte     = byte_i;
    end else if (rec_end) begin
      res_o.kind        = csvtok_pkg::KIND_RECORD;
      res_o.start       = rep_start;
      res_o.length      = rep_len;
      res_o.trunc_flags = rep_trunc;
    end else if (empty_end) begin
      res_o.kind = csvtok_pkg::KIND_EMPTY;
    end
  end

  // State registers, advanced once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_pos_q   <= '0;
      in_quote_q    <= 1'b0;
      quote_seen_q  <= 1'b0;
      started_q     <= 1'b0;
      has_data_q    <= 1'b0;
      bom_match_q   <= '0;
      trunc_q       <= '0;
      first_valid_q <= '0;
      ab_first_q    <= '0;
      ab_valid_q    <= 1'b0;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        raw_count_q[i] <= '0;
        first_ns_q[i]  <= '0;
        last_end_q[i]  <= '0;
      end
    end else if (step_i) begin
      field_pos_q   <= field_pos_d;
      in_quote_q    <= in_quote_d;
      quote_seen_q  <= quote_seen_d;
      started_q     <= started_d;
      has_data_q    <= has_data_d;
      bom_match_q   <= bom_match_d;
      trunc_q       <= trunc_d;
      first_valid_q <= first_valid_d;
      ab_first_q    <= ab_first_d;
      ab_valid_q    <= ab_valid_d;
      raw_count_q   <= raw_count_d;
      first_ns_q    <= first_ns_d;
      last_end_q    <= last_end_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/csv_record_tokenizer.sv =====
// Top level of the CSV record tokenizer: input register, parser and result register.
//
// Usage: items arrive on in_i, each a data byte (func 0) or an end-of-input mark
// (func 1). Results leave on out_o: a stored byte with its field and raw position,
// the bounds of a finished record, or an end-of-input mark when no record was open.
// An item causes at most one result. The limits are written on cfg_i (index 0 is
// the first field limit, index 1 the limit of the other fields); the user must
// write them only while no item is in flight, and the block itself does not
// enforce this. The cfg_i channel is always ready. An item accepted from in_i
// is held in the input register, and its result is loaded into the output
// register when the parser steps on it, which waits while the output register
// is full and not being taken. The block takes one item per cycle while the
// receiver keeps taking results; the parser state is updated once per item.
// Reset clears the record state and both registers, and sets the limits to 2048
// and 256. When the receiver stalls, the result waits in the output register and
// the next item waits in the input register; in_i.ready falls only when both are
// full and the output register is not being emptied in that cycle.
`default_nettype none

module csv_record_tokenizer #(
  parameter int unsigned POS_WIDTH   = 12,
  parameter int unsigned FIELD_COUNT = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  csvtok_in_if.sink     in_i,
  csvtok_out_if.source  out_o,
  csvtok_cfg_if.sink    cfg_i
);

  logic [csvtok_pkg::LIMIT_W-1:0] first_limit, other_limit;

  csvtok_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_i),
    .first_limit_o (first_limit),
    .other_limit_o (other_limit)
  );

  // Input register.
  logic       in_valid_q;
  logic       in_func_q;
  logic [7:0] in_byte_q;
  logic       step;
  logic       out_free;

  // Result register.
  logic             out_valid_q;
  csvtok_pkg::res_t res_q;
  logic             res_valid;
  csvtok_pkg::res_t res;

  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_func_q <= in_i.func;
      in_byte_q <= in_i.data_byte;
    end
  end

  csvtok_parser #(
    .POS_WIDTH   (POS_WIDTH),
    .FIELD_COUNT (FIELD_COUNT)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .func_i        (in_func_q),
    .byte_i        (in_byte_q),
    .first_limit_i (first_limit),
    .other_limit_i (other_limit),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Result register: loaded when the parser produces an item, emptied when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      res_q <= res;
    end
  end

  // Output channel fields.
  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = res_q.kind;
  assign out_o.field_number  = res_q.field_number;
  assign out_o.raw_position  = res_q.raw_position;
  assign out_o.out_byte      = res_q.out_byte;
  assign out_o.first_start   = res_q.start[0];
  assign out_o.first_length  = res_q.length[0];
  assign out_o.second_start  = res_q.start[1];
  assign out_o.second_length = res_q.length[1];
  assign out_o.third_start   = res_q.start[2];
  assign out_o.third_length  = res_q.length[2];
  assign out_o.trunc_flags   = res_q.trunc_flags;

endmodule

`default_nettype wire

// ===== tb/csv_record_tokenizer_tb.sv =====
// Self-checking testbench of the CSV record tokenizer with its own parser model and checker.
`timescale 1ns / 100ps

module csv_record_tokenizer_tb;

  // Function codes of an input item.
  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  // Register indexes with no register behind them.
  localparam logic [csvtok_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [csvtok_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // Largest position a field limit can reach.
  localparam int unsigned POS_CAP = 1 << csvtok_pkg::POS_OUT_W;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int DRAIN_GUARD  = 50000;
  localparam int PHASE_ITEMS  = 80;

  logic clk_i = 1'b0;
  logic rst_ni;

  csvtok_in_if  in_if ();
  csvtok_out_if out_if ();
  csvtok_cfg_if cfg_if ();

  csv_record_tokenizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Clock of 10 ns.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Model state: limits and the record being parsed.
  logic [csvtok_pkg::LIMIT_W-1:0] lim_first;
  logic [csvtok_pkg::LIMIT_W-1:0] lim_other;
  int unsigned        field_idx;
  bit                 quoted;
  bit                 quote_pending;
  bit                 rec_open;
  bit                 field_has_data;
  int unsigned        bom_seen;
  int unsigned        byte_count [csvtok_pkg::REC_FIELDS];
  bit                 overflowed [csvtok_pkg::REC_FIELDS];
  int unsigned        lead_pos   [csvtok_pkg::REC_FIELDS];
  bit                 lead_ok    [csvtok_pkg::REC_FIELDS];
  int unsigned        tail_end   [csvtok_pkg::REC_FIELDS];
  int unsigned        post_bom_pos;
  bit                 post_bom_ok;

  logic [7:0] bom_seq [3] = '{csvtok_pkg::BOM_B0, csvtok_pkg::BOM_B1, csvtok_pkg::BOM_B2};

  // Results still owed by the block, oldest first.
  csvtok_pkg::res_t awaited_tokens [$];

  int  failures    = 0;
  int  sent_items  = 0;
  int  burst_left  = 0;
  bit  gaps_on     = 1'b0;
  bit  stall_on    = 1'b0;
  bit  hold_pending = 1'b0;

  function automatic bit is_blank(input logic [7:0] c);
    return (c == csvtok_pkg::CH_SPACE) ||
           ((c >= csvtok_pkg::CH_TAB) && (c <= csvtok_pkg::CH_CR));
  endfunction

  function automatic void clear_record_state();
    field_idx      = 0;
    quoted         = 1'b0;
    quote_pending  = 1'b0;
    rec_open       = 1'b0;
    field_has_data = 1'b0;
    bom_seen       = 0;
    for (int i = 0; i < csvtok_pkg::REC_FIELDS; i++) begin
      byte_count[i] = 0;
      overflowed[i] = 1'b0;
      lead_pos[i]   = 0;
      lead_ok[i]    = 1'b0;
      tail_end[i]   = 0;
    end
    post_bom_pos = 0;
    post_bom_ok  = 1'b0;
  endfunction

  // Effective limit of a field; values past the position range saturate.
  function automatic int unsigned field_cap(input int unsigned f);
    int unsigned lim;
    lim = (f == 0) ? 32'(lim_first) : 32'(lim_other);
    return (lim > POS_CAP) ? POS_CAP : lim;
  endfunction

  // Keeps one byte in the current field, or marks the field as truncated.
  function automatic bit store_byte(input logic [7:0] c, output csvtok_pkg::res_t r);
    int unsigned f;
    int unsigned p;
    r = '0;
    f = field_idx;
    if (f >= csvtok_pkg::REC_FIELDS) return 1'b0;
    p = byte_count[f];
    if (p >= field_cap(f)) begin
      overflowed[f] = 1'b1;
      return 1'b0;
    end
    if (!is_blank(c)) begin
      if (!lead_ok[f]) begin
        lead_ok[f]  = 1'b1;
        lead_pos[f] = p;
      end
      tail_end[f] = p + 1;
      if (f == 0 && p >= 3 && !post_bom_ok) begin
        post_bom_ok  = 1'b1;
        post_bom_pos = p;
      end
    end
    if (f == 0 && p < 3 && bom_seen == p && c == bom_seq[p]) bom_seen = p + 1;
    byte_count[f]  = p + 1;
    r.kind         = csvtok_pkg::KIND_BYTE;
    r.field_number = f[1:0];
    r.raw_position = p[csvtok_pkg::POS_OUT_W-1:0];
    r.out_byte     = c;
    return 1'b1;
  endfunction

  // Trimmed bounds of every field of the finished record.
  function automatic bit close_record(output csvtok_pkg::res_t r);
    bit          ok;
    int unsigned s;
    int unsigned len;
    r = '0;
    r.kind = csvtok_pkg::KIND_RECORD;
    for (int i = 0; i < csvtok_pkg::REC_FIELDS; i++) begin
      ok  = lead_ok[i];
      s   = lead_pos[i];
      len = 0;
      if (i == 0 && bom_seen == 3) begin
        ok = post_bom_ok;
        s  = post_bom_pos;
      end
      if (ok && tail_end[i] > s) len = tail_end[i] - s;
      else s = 0;
      r.start[i]       = s[csvtok_pkg::POS_OUT_W-1:0];
      r.length[i]      = len[csvtok_pkg::LEN_OUT_W-1:0];
      r.trunc_flags[i] = overflowed[i];
    end
    clear_record_state();
    return 1'b1;
  endfunction

  // Expected result of one input item, if it causes one.
  function automatic bit tokenize_item(input logic fn, input logic [7:0] c,
                                       output csvtok_pkg::res_t r);
    bit n;
    r = '0;
    if (fn == FUNC_END) begin
      if (!rec_open) begin
        clear_record_state();
        r.kind = csvtok_pkg::KIND_EMPTY;
        return 1'b1;
      end
      return close_record(r);
    end
    if (quoted) begin
      if (quote_pending) begin
        if (c == csvtok_pkg::CH_QUOTE) begin
          quote_pending  = 1'b0;
          field_has_data = 1'b1;
          rec_open       = 1'b1;
          return store_byte(c, r);
        end
        quoted        = 1'b0;
        quote_pending = 1'b0;
      end else begin
        rec_open = 1'b1;
        if (c == csvtok_pkg::CH_QUOTE) begin
          quote_pending = 1'b1;
          return 1'b0;
        end
        field_has_data = 1'b1;
        return store_byte(c, r);
      end
    end
    if (c == csvtok_pkg::CH_QUOTE) begin
      n = 1'b0;
      if (!field_has_data) quoted = 1'b1;
      else n = store_byte(c, r);
      field_has_data = 1'b1;
      rec_open       = 1'b1;
      return n;
    end
    if (c == csvtok_pkg::CH_COMMA) begin
      if (field_idx < csvtok_pkg::REC_FIELDS) field_idx++;
      field_has_data = 1'b0;
      rec_open       = 1'b1;
      return 1'b0;
    end
    if (c == csvtok_pkg::CH_CR) return 1'b0;
    if (c == csvtok_pkg::CH_LF) begin
      if (!rec_open && !field_has_data && field_idx == 0) return 1'b0;
      return close_record(r);
    end
    field_has_data = 1'b1;
    rec_open       = 1'b1;
    return store_byte(c, r);
  endfunction

  // Sends one item, opening a random gap between bursts when gaps are enabled.
  task automatic send_item(input logic fn, input logic [7:0] b);
    csvtok_pkg::res_t r;
    int   gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.func      <= fn;
    in_if.data_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    sent_items++;
    if (tokenize_item(fn, b, r)) awaited_tokens.insert(awaited_tokens.size(), r);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(FUNC_DATA, s[i]);
  endtask

  // Stops sending and waits until every owed result has come out.
  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (awaited_tokens.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    if (guard >= DRAIN_GUARD) begin
      $error("results stopped coming with %0d still owed", awaited_tokens.size());
      failures++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [csvtok_pkg::CFG_IDX_W-1:0] idx,
                             input logic [csvtok_pkg::LIMIT_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == csvtok_pkg::CFG_FIRST_LIMIT) lim_first = value;
    else if (idx == csvtok_pkg::CFG_OTHER_LIMIT) lim_other = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly printable bytes and blanks, never a separator or a quote.
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0: c = $urandom_range(0, 1) ? csvtok_pkg::CH_SPACE : csvtok_pkg::CH_TAB;
      1: begin
        do c = 8'($urandom_range(0, 255));
        while (c == csvtok_pkg::CH_QUOTE || c == csvtok_pkg::CH_COMMA ||
               c == csvtok_pkg::CH_CR || c == csvtok_pkg::CH_LF);
      end
      default: c = 8'h61 + 8'($urandom_range(0, 25));
    endcase
    return c;
  endfunction

  task automatic send_plain(input int len);
    repeat (len) send_item(FUNC_DATA, plain_byte());
  endtask

  // One well-formed record with random content, or now and then a run of noise.
  task automatic send_random_record();
    int         nf;
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 10))
        send_item(($urandom_range(0, 15) == 0) ? FUNC_END : FUNC_DATA,
                  8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 9) == 0) begin
      send_item(FUNC_DATA, csvtok_pkg::BOM_B0);
      send_item(FUNC_DATA, csvtok_pkg::BOM_B1);
      send_item(FUNC_DATA, csvtok_pkg::BOM_B2);
    end
    nf = $urandom_range(1, 5);
    for (int k = 0; k < nf; k++) begin
      if (k > 0) send_item(FUNC_DATA, csvtok_pkg::CH_COMMA);
      case ($urandom_range(0, 3))
        0: repeat ($urandom_range(0, 3))
             send_item(FUNC_DATA,
                       $urandom_range(0, 1) ? csvtok_pkg::CH_SPACE : csvtok_pkg::CH_TAB);
        1: send_plain($urandom_range(1, 6));
        2: begin
          // Quoted field: any byte inside, quotes doubled.
          send_item(FUNC_DATA, csvtok_pkg::CH_QUOTE);
          repeat ($urandom_range(0, 5)) begin
            c = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 5) == 0) c = csvtok_pkg::CH_QUOTE;
            send_item(FUNC_DATA, c);
            if (c == csvtok_pkg::CH_QUOTE) send_item(FUNC_DATA, csvtok_pkg::CH_QUOTE);
          end
          send_item(FUNC_DATA, csvtok_pkg::CH_QUOTE);
          send_plain($urandom_range(0, 1));
        end
        default: begin
          send_plain($urandom_range(1, 3));
          send_item(FUNC_DATA, csvtok_pkg::CH_QUOTE);
          send_plain($urandom_range(0, 3));
        end
      endcase
    end
    case ($urandom_range(0, 9))
      6, 7: send_text("\r\n");
      8:    send_item(FUNC_END, 8'($urandom_range(0, 255)));
      9:    send_text("\n\n");
      default: send_item(FUNC_DATA, csvtok_pkg::CH_LF);
    endcase
  endtask

  function automatic logic [csvtok_pkg::LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 6))
      0: return csvtok_pkg::LIMIT_W'($urandom_range(1, 4));
      1: return csvtok_pkg::LIMIT_W'($urandom_range(1, 12));
      2: return csvtok_pkg::LIMIT_W'(POS_CAP);
      3: return '0;
      4: return '1;
      5: return csvtok_pkg::LIMIT_W'($urandom_range(1, 8191));
      default: return csvtok_pkg::LIMIT_W'($urandom_range(3, 40));
    endcase
  endfunction

  // Quoted field with a doubled quote, quote in mid-field, carriage return.
  task automatic test_quoting();
    send_text("\"x\"\"y\",a\"b, c \r\n");
    settle();
  endtask

  // Blank lines, an all-blank field, surplus commas and end-of-input marks.
  task automatic test_blank_and_end();
    send_text("\n\r\n");
    send_item(FUNC_END, 8'h00);
    send_text("\t ,,,,z\n");
    send_text("\"ab");
    send_item(FUNC_END, 8'hFF);
    send_item(FUNC_END, 8'h5A);
    settle();
  endtask

  // Byte order mark skip, a partial mark, a mark alone, and byte extremes.
  task automatic test_bom();
    send_item(FUNC_DATA, csvtok_pkg::BOM_B0);
    send_item(FUNC_DATA, csvtok_pkg::BOM_B1);
    send_item(FUNC_DATA, csvtok_pkg::BOM_B2);
    send_text(" k,");
    send_item(FUNC_DATA, 8'hFF);
    send_item(FUNC_DATA, 8'h00);
    send_item(FUNC_DATA, csvtok_pkg::CH_LF);
    send_item(FUNC_DATA, csvtok_pkg::BOM_B0);
    send_item(FUNC_DATA, 8'h41);
    send_item(FUNC_DATA, csvtok_pkg::BOM_B2);
    send_item(FUNC_DATA, csvtok_pkg::CH_LF);
    send_item(FUNC_DATA, csvtok_pkg::BOM_B0);
    send_item(FUNC_DATA, csvtok_pkg::BOM_B1);
    send_item(FUNC_DATA, csvtok_pkg::BOM_B2);
    send_item(FUNC_DATA, csvtok_pkg::CH_LF);
    settle();
  endtask

  // Smallest limits, a zero limit and writes to unused register indexes.
  task automatic test_field_limits();
    write_limit(csvtok_pkg::CFG_FIRST_LIMIT, 13'd1);
    write_limit(csvtok_pkg::CFG_OTHER_LIMIT, 13'd0);
    write_limit(CFG_SPARE_A, 13'd5);
    write_limit(CFG_SPARE_B, '1);
    send_text("ab,cd,ef\n");
    settle();
    write_limit(csvtok_pkg::CFG_FIRST_LIMIT, 13'd3);
    write_limit(csvtok_pkg::CFG_OTHER_LIMIT, 13'd2);
    send_item(FUNC_DATA, csvtok_pkg::BOM_B0);
    send_item(FUNC_DATA, csvtok_pkg::BOM_B1);
    send_item(FUNC_DATA, csvtok_pkg::BOM_B2);
    send_text("xy,pq r\n");
    settle();
  endtask

  // A first field running past its limit, with the other limit at the top of the range.
  task automatic test_long_field();
    write_limit(csvtok_pkg::CFG_FIRST_LIMIT, 13'd16);
    write_limit(csvtok_pkg::CFG_OTHER_LIMIT, csvtok_pkg::LIMIT_W'(POS_CAP));
    for (int i = 0; i < 18; i++) send_item(FUNC_DATA, 8'h41 + 8'(i % 26));
    send_text(",q\n");
    settle();
  endtask

  // Receiver holds off for a long stretch while a record keeps coming.
  task automatic test_backpressure();
    stall_on     = 1'b0;
    gaps_on      = 1'b0;
    hold_pending = 1'b1;
    send_text("alpha, beta ,\"ga\"\"mma\",delta,epsilon\r\n");
    settle();
  endtask

  // Phases of random records under random limits (the last phase under the reset limits) and idling.
  task automatic test_random_records();
    int first_item;
    for (int ph = 0; ph < 5; ph++) begin
      write_limit(csvtok_pkg::CFG_FIRST_LIMIT,
                  (ph == 4) ? csvtok_pkg::FIRST_LIMIT_RST : pick_limit());
      write_limit(csvtok_pkg::CFG_OTHER_LIMIT,
                  (ph == 4) ? csvtok_pkg::OTHER_LIMIT_RST : pick_limit());
      gaps_on  = (ph != 2) && ($urandom_range(0, 3) != 0);
      stall_on = (ph != 2) && ($urandom_range(0, 3) != 0);
      if (ph == 0) begin
        gaps_on  = 1'b1;
        stall_on = 1'b1;
      end
      first_item = sent_items;
      while (sent_items - first_item < PHASE_ITEMS) send_random_record();
      settle();
    end
  endtask

  // Receiver: long hold-off on request, otherwise random stalls when enabled.
  initial begin : receiver
    int hold_left;
    int stall_run;
    hold_left    = 0;
    stall_run    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_left    = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_run > 0) begin
        stall_run--;
        out_if.ready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        stall_run = $urandom_range(0, 7);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name,
                                      input logic [csvtok_pkg::LEN_OUT_W-1:0] want,
                                      input logic [csvtok_pkg::LEN_OUT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // Each accepted result against the oldest owed one.
  always @(posedge clk_i) begin : result_checker
    csvtok_pkg::res_t e;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (awaited_tokens.size() == 0) begin
        $error("result item with none owed, kind %0d", out_if.kind);
        failures++;
      end else begin
        e = awaited_tokens.pop_front();
        check_field("kind", csvtok_pkg::LEN_OUT_W'(e.kind),
                    csvtok_pkg::LEN_OUT_W'(out_if.kind));
        check_field("field_number", csvtok_pkg::LEN_OUT_W'(e.field_number),
                    csvtok_pkg::LEN_OUT_W'(out_if.field_number));
        check_field("raw_position", csvtok_pkg::LEN_OUT_W'(e.raw_position),
                    csvtok_pkg::LEN_OUT_W'(out_if.raw_position));
        check_field("out_byte", csvtok_pkg::LEN_OUT_W'(e.out_byte),
                    csvtok_pkg::LEN_OUT_W'(out_if.out_byte));
        check_field("first_start", csvtok_pkg::LEN_OUT_W'(e.start[0]),
                    csvtok_pkg::LEN_OUT_W'(out_if.first_start));
        check_field("first_length", e.length[0], out_if.first_length);
        check_field("second_start", csvtok_pkg::LEN_OUT_W'(e.start[1]),
                    csvtok_pkg::LEN_OUT_W'(out_if.second_start));
        check_field("second_length", e.length[1], out_if.second_length);
        check_field("third_start", csvtok_pkg::LEN_OUT_W'(e.start[2]),
                    csvtok_pkg::LEN_OUT_W'(out_if.third_start));
        check_field("third_length", e.length[2], out_if.third_length);
        check_field("trunc_flags", csvtok_pkg::LEN_OUT_W'(e.trunc_flags),
                    csvtok_pkg::LEN_OUT_W'(out_if.trunc_flags));
      end
    end
  end

  // Run limit.
  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    in_if.valid     = 1'b0;
    in_if.func      = FUNC_DATA;
    in_if.data_byte = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = csvtok_pkg::CFG_FIRST_LIMIT;
    cfg_if.data     = '0;
    rst_ni          = 1'b0;
    lim_first       = csvtok_pkg::FIRST_LIMIT_RST;
    lim_other       = csvtok_pkg::OTHER_LIMIT_RST;
    clear_record_state();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_quoting();
    test_blank_and_end();
    test_bom();
    test_field_limits();
    test_long_field();
    test_backpressure();
    test_random_records();

    settle();
    if (awaited_tokens.size() != 0) begin
      $error("%0d expected results never arrived", awaited_tokens.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
